### sv/tmh_pkg.sv
`timescale 1ns / 1ps

package tmh_pkg;

   // field widths
   localparam int XY_W   = 16;
   localparam int WORD_W = 32;
   localparam int Q_W    = 6;

   // phase divider: integer steps, then turn fraction steps
   localparam int NUM_W = 46;
   localparam int DEN_W = 64;
   localparam int PH_W  = 32;

   // rotator
   localparam int Z_W      = 34;
   localparam int CORD_W   = 28;
   localparam int CORD_ONE = 24;
   localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;

   // momentum path
   localparam int A_W    = 45;
   localparam int DIVR_W = 59;
   localparam int QUO_W  = 32;
   localparam int PROD_W = XY_W + CORD_W;

   localparam int ION_MASS = 256;
   localparam logic [WORD_W-1:0] PI20     = 32'd3294199;
   localparam logic [WORD_W-1:0] VSCALE_RST = 32'd7668914;

   localparam int SH_FREE = 18;
   localparam int SH_ION  = 30;
   localparam int SH_ELEC = 38;

   // arctan(2^-i) in 2^-32 turns, rounded
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DIV = 2'd1,
      STATUS_SAT      = 2'd2
   } tmh_status_type;

   typedef enum logic [1:0] {
      REG_FIELD     = 2'd0,
      REG_CLOCKWISE = 2'd1,
      REG_PERIOD    = 2'd2,
      REG_VSCALE    = 2'd3
   } tmh_reg_type;

   typedef enum logic [1:0] {
      SHIFT_FREE = 2'd0,
      SHIFT_ION  = 2'd1,
      SHIFT_ELEC = 2'd2
   } tmh_shift_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x_pos;
      logic signed [XY_W-1:0] y_pos;
      logic [WORD_W-1:0]      flight_time;
      logic [WORD_W-1:0]      particle_mass;
      logic [Q_W-1:0]         particle_charge;
      logic                   ion;
      logic                   zero_div;
   } tmh_hit_type;

   typedef struct packed {
      logic [1:0]        neg;
      logic              zero_div;
      tmh_shift_type     shift_sel;
      logic [DIVR_W-1:0] div;
      logic [WORD_W-1:0] k;
      logic [WORD_W-1:0] pf;
   } tmh_mul_side_type;

   typedef struct packed {
      logic [1:0] neg;
      logic [1:0] ovf;
      logic       zero_div;
   } tmh_div_side_type;

endpackage

### sv/tmh_phase.sv
`timescale 1ns / 1ps

// restoring divider, one bit per stage; keeps the fraction bits of num / den
module tmh_phase #(
   parameter int SW = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_vld,
   input  logic [tmh_pkg::NUM_W-1:0]  in_num,
   input  logic [tmh_pkg::DEN_W-1:0]  in_den,
   input  logic [SW-1:0]              in_sb,
   output logic                       out_vld,
   output logic [tmh_pkg::PH_W-1:0]   out_ph,
   output logic [SW-1:0]              out_sb
);

   localparam int NW    = tmh_pkg::NUM_W;
   localparam int DW    = tmh_pkg::DEN_W;
   localparam int PW    = tmh_pkg::PH_W;
   localparam int NSTEP = NW + PW;

   logic          vld_ff [NSTEP];
   logic [DW-1:0] rem_ff [NSTEP];
   logic [DW-1:0] den_ff [NSTEP];
   logic [NW-1:0] num_ff [NSTEP];
   logic [PW-1:0] ph_ff  [NSTEP];
   logic [SW-1:0] sb_ff  [NSTEP];

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic          vld_prev;
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [NW-1:0] num_prev;
      logic [PW-1:0] ph_prev;
      logic [SW-1:0] sb_prev;
      logic          nbit;
      logic [DW:0]   trial;
      logic          ge;

      if (i == 0) begin : g_first
         assign vld_prev = in_vld;
         assign rem_prev = '0;
         assign den_prev = in_den;
         assign num_prev = in_num;
         assign ph_prev  = '0;
         assign sb_prev  = in_sb;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign num_prev = num_ff[i-1];
         assign ph_prev  = ph_ff[i-1];
         assign sb_prev  = sb_ff[i-1];
      end

      if (i < NW) begin : g_int
         assign nbit = num_prev[NW-1-i];
      end else begin : g_frac
         assign nbit = 1'b0;
      end

      assign trial = {rem_prev, nbit};
      assign ge    = (trial >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
            den_ff[i] <= den_prev;
            num_ff[i] <= num_prev;
            ph_ff[i]  <= {ph_prev[PW-2:0], ge};
            sb_ff[i]  <= sb_prev;
         end
      end
   end

   assign out_vld = vld_ff[NSTEP-1];
   assign out_ph  = ph_ff[NSTEP-1];
   assign out_sb  = sb_ff[NSTEP-1];

endmodule

### sv/tmh_cordic.sv
`timescale 1ns / 1ps

// rotation CORDIC, one micro-rotation per stage, start vector (2^24, 0)
module tmh_cordic #(
   parameter int STAGES = 24,
   parameter int SW     = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_vld,
   input  logic signed [tmh_pkg::Z_W-1:0]     in_z,
   input  logic [SW-1:0]                      in_sb,
   output logic                               out_vld,
   output logic signed [tmh_pkg::CORD_W-1:0]  out_sin,
   output logic signed [tmh_pkg::CORD_W-1:0]  out_cos,
   output logic [SW-1:0]                      out_sb
);

   localparam int CW = tmh_pkg::CORD_W;
   localparam int ZW = tmh_pkg::Z_W;
   localparam logic signed [CW-1:0] START = CW'(1) <<< tmh_pkg::CORD_ONE;

   logic                 vld_ff [STAGES];
   logic signed [CW-1:0] cx_ff  [STAGES];
   logic signed [CW-1:0] cy_ff  [STAGES];
   logic signed [ZW-1:0] z_ff   [STAGES];
   logic [SW-1:0]        sb_ff  [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      logic                 vld_prev;
      logic signed [CW-1:0] cx_prev;
      logic signed [CW-1:0] cy_prev;
      logic signed [ZW-1:0] z_prev;
      logic [SW-1:0]        sb_prev;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] ang;

      if (i == 0) begin : g_first
         assign vld_prev = in_vld;
         assign cx_prev  = START;
         assign cy_prev  = '0;
         assign z_prev   = in_z;
         assign sb_prev  = in_sb;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign cx_prev  = cx_ff[i-1];
         assign cy_prev  = cy_ff[i-1];
         assign z_prev   = z_ff[i-1];
         assign sb_prev  = sb_ff[i-1];
      end

      assign dx  = cy_prev >>> i;
      assign dy  = cx_prev >>> i;
      assign ang = signed'({2'b00, tmh_pkg::ATAN_TURNS[i]});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_prev[ZW-1]) begin
               cx_ff[i] <= cx_prev - dx;
               cy_ff[i] <= cy_prev + dy;
               z_ff[i]  <= z_prev - ang;
            end else begin
               cx_ff[i] <= cx_prev + dx;
               cy_ff[i] <= cy_prev - dy;
               z_ff[i]  <= z_prev + ang;
            end
            sb_ff[i] <= sb_prev;
         end
      end
   end

   assign out_vld = vld_ff[STAGES-1];
   assign out_sin = cx_ff[STAGES-1];
   assign out_cos = -cy_ff[STAGES-1];
   assign out_sb  = sb_ff[STAGES-1];

endmodule

### sv/tmh_wmul.sv
`timescale 1ns / 1ps

// two-lane wide x 32 multiply: 32x32 partial products, then the sum
module tmh_wmul #(
   parameter int AW = 45,
   parameter int SW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_vld,
   input  logic [1:0][AW-1:0]    in_a,
   input  logic [31:0]           in_b,
   input  logic [SW-1:0]         in_sb,
   output logic                  out_vld,
   output logic [1:0][AW+31:0]   out_p,
   output logic [SW-1:0]         out_sb
);

   localparam int NC   = (AW + 31) / 32;
   localparam int PADW = NC * 32;

   logic [1:0][PADW-1:0]       a_pad;
   logic [1:0][NC-1:0][63:0]   pp_in;
   logic [1:0][NC-1:0][63:0]   pp_ff;
   logic [1:0][PADW+31:0]      acc;
   logic [1:0][AW+31:0]        p_ff;
   logic                       vld1_ff, vld2_ff;
   logic [SW-1:0]              sb1_ff, sb2_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         a_pad[l] = PADW'(in_a[l]);
         for (int c = 0; c < NC; c++) begin
            pp_in[l][c] = a_pad[l][c*32 +: 32] * in_b;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         acc[l] = '0;
         for (int c = 0; c < NC; c++) begin
            acc[l] = acc[l] + ((PADW+32)'(pp_ff[l][c]) << (32 * c));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (advance) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_ff  <= pp_in;
         sb1_ff <= in_sb;
         for (int l = 0; l < 2; l++) begin
            p_ff[l] <= acc[l][AW+31:0];
         end
         sb2_ff <= sb1_ff;
      end
   end

   assign out_vld = vld2_ff;
   assign out_p   = p_ff;
   assign out_sb  = sb2_ff;

endmodule

### sv/tmh_qdiv.sv
`timescale 1ns / 1ps

// two-lane restoring divider, 32 quotient bits, one per stage;
// the starting remainder must already be below the divisor
module tmh_qdiv #(
   parameter int SW = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_vld,
   input  logic [1:0][tmh_pkg::DIVR_W-1:0]   in_rem,
   input  logic [1:0][tmh_pkg::QUO_W-1:0]    in_low,
   input  logic [tmh_pkg::DIVR_W-1:0]        in_div,
   input  logic [SW-1:0]                     in_sb,
   output logic                              out_vld,
   output logic [1:0][tmh_pkg::QUO_W-1:0]    out_quo,
   output logic [SW-1:0]                     out_sb
);

   localparam int DW = tmh_pkg::DIVR_W;
   localparam int QW = tmh_pkg::QUO_W;

   logic                vld_ff [QW];
   logic [1:0][DW-1:0]  rem_ff [QW];
   logic [1:0][QW-1:0]  low_ff [QW];
   logic [1:0][QW-1:0]  quo_ff [QW];
   logic [DW-1:0]       div_ff [QW];
   logic [SW-1:0]       sb_ff  [QW];

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic               vld_prev;
      logic [1:0][DW-1:0] rem_prev;
      logic [1:0][QW-1:0] low_prev;
      logic [1:0][QW-1:0] quo_prev;
      logic [DW-1:0]      div_prev;
      logic [SW-1:0]      sb_prev;
      logic [1:0][DW:0]   trial;
      logic [1:0]         ge;

      if (i == 0) begin : g_first
         assign vld_prev = in_vld;
         assign rem_prev = in_rem;
         assign low_prev = in_low;
         assign quo_prev = '0;
         assign div_prev = in_div;
         assign sb_prev  = in_sb;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign low_prev = low_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign div_prev = div_ff[i-1];
         assign sb_prev  = sb_ff[i-1];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l] = {rem_prev[l], low_prev[l][QW-1]};
            ge[l]    = (trial[l] >= {1'b0, div_prev});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[i][l] <= ge[l] ? DW'(trial[l] - {1'b0, div_prev}) : trial[l][DW-1:0];
               low_ff[i][l] <= {low_prev[l][QW-2:0], 1'b0};
               quo_ff[i][l] <= {quo_prev[l][QW-2:0], ge[l]};
            end
            div_ff[i] <= div_prev;
            sb_ff[i]  <= sb_prev;
         end
      end
   end

   assign out_vld = vld_ff[QW-1];
   assign out_quo = quo_ff[QW-1];
   assign out_sb  = sb_ff[QW-1];

endmodule

### sv/transverse_momentum_from_hit.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle unless the consumer holds the output word; the whole
// datapath is a single stalled pipeline. It holds the 78-step phase divider, the CORDIC
// rotator and the 32-step momentum divider, each one bit or one micro-rotation
// per stage.
// Reset (synchronous, active high) empties the pipeline and restores the registers
// to field off, counterclockwise, period 0, velocity scale 7668914.

module transverse_momentum_from_hit #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic         clock,
   input  logic         reset,
   // hit words
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // x_pos[15:0], y_pos[31:16], flight_time[63:32],
                                     // particle_mass[95:64], particle_charge[101:96]
   // momentum words
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // mom_x[31:0], mom_y[63:32]
   output logic [1:0]   rsp_tuser,   // status[1:0]
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int A_W    = tmh_pkg::A_W;
   localparam int DIVR_W = tmh_pkg::DIVR_W;
   localparam int P3_W   = A_W + 96;
   localparam int HI_W   = P3_W - 32;
   localparam int HIT_W  = $bits(tmh_pkg::tmh_hit_type);
   localparam int MUL_SW = $bits(tmh_pkg::tmh_mul_side_type);
   localparam int DIV_SW = $bits(tmh_pkg::tmh_div_side_type);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic                 field_ff, cw_ff;
   logic [31:0]          period_ff, vscale_ff;
   logic                 csr_wr;
   tmh_pkg::tmh_reg_type csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = tmh_pkg::tmh_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff  <= 1'b0;
         cw_ff     <= 1'b0;
         period_ff <= '0;
         vscale_ff <= tmh_pkg::VSCALE_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            tmh_pkg::REG_FIELD:     field_ff  <= csr_pwdata[0];
            tmh_pkg::REG_CLOCKWISE: cw_ff     <= csr_pwdata[0];
            tmh_pkg::REG_PERIOD:    period_ff <= csr_pwdata;
            tmh_pkg::REG_VSCALE:    vscale_ff <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         tmh_pkg::REG_FIELD:     csr_prdata = {31'b0, field_ff};
         tmh_pkg::REG_CLOCKWISE: csr_prdata = {31'b0, cw_ff};
         tmh_pkg::REG_PERIOD:    csr_prdata = period_ff;
         tmh_pkg::REG_VSCALE:    csr_prdata = vscale_ff;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline advance: every stage moves together unless the output word
   // is held by the consumer. The output register parts the two sides.
   // ---------------------------------------------------------------------
   logic advance;
   logic rsp_vld_ff;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------------
   // s0: capture
   // ---------------------------------------------------------------------
   logic                 s0_vld_ff;
   tmh_pkg::tmh_hit_type s0_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (advance) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_hit_ff.x_pos           <= signed'(req_tdata[15:0]);
         s0_hit_ff.y_pos           <= signed'(req_tdata[31:16]);
         s0_hit_ff.flight_time     <= req_tdata[63:32];
         s0_hit_ff.particle_mass   <= req_tdata[95:64];
         s0_hit_ff.particle_charge <= req_tdata[101:96];
         s0_hit_ff.ion             <= 1'b0;
         s0_hit_ff.zero_div        <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // s1: phase numerator and denominator. Ions scale the electron period
   // by mass / charge, so num = t*256*q and den = P*m.
   // ---------------------------------------------------------------------
   logic                          s1_vld_ff;
   tmh_pkg::tmh_hit_type          s1_hit_ff;
   tmh_pkg::tmh_hit_type          s1_hit_in;
   logic [tmh_pkg::NUM_W-1:0]     s1_num_ff;
   logic [tmh_pkg::DEN_W-1:0]     s1_den_ff;
   logic                          s1_ion;

   assign s1_ion = s0_hit_ff.particle_mass > 32'(tmh_pkg::ION_MASS);

   always_comb begin
      s1_hit_in     = s0_hit_ff;
      s1_hit_in.ion = s1_ion;
      // zero divisor: t = 0 without field, P = 0 with it (m > 256 for ions)
      s1_hit_in.zero_div = field_ff ? (period_ff == '0)
                                    : (s0_hit_ff.flight_time == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_hit_ff <= s1_hit_in;
         s1_num_ff <= s1_ion ? ({14'b0, s0_hit_ff.flight_time} *
                                {32'b0, s0_hit_ff.particle_charge, 8'b0})
                             : {14'b0, s0_hit_ff.flight_time};
         s1_den_ff <= s1_ion ? ({32'b0, period_ff} * {32'b0, s0_hit_ff.particle_mass})
                             : {32'b0, period_ff};
      end
   end

   // ---------------------------------------------------------------------
   // Phase as a 32-bit turn fraction: (num mod den) / den
   // ---------------------------------------------------------------------
   logic                         ph_vld;
   logic [tmh_pkg::PH_W-1:0]     ph_val;
   tmh_pkg::tmh_hit_type         ph_hit;

   tmh_phase #(
      .SW (HIT_W)
   ) u_phase (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_vld  (s1_vld_ff),
      .in_num  (s1_num_ff),
      .in_den  (s1_den_ff),
      .in_sb   (s1_hit_ff),
      .out_vld (ph_vld),
      .out_ph  (ph_val),
      .out_sb  (ph_hit)
   );

   // ---------------------------------------------------------------------
   // Rotator: rotate by half phase minus a quarter turn, so x ~ sin, -y ~ cos
   // ---------------------------------------------------------------------
   logic signed [tmh_pkg::Z_W-1:0]    cd_z;
   tmh_pkg::tmh_hit_type              cd_in_hit;
   logic                              cd_vld;
   logic signed [tmh_pkg::CORD_W-1:0] cd_sin, cd_cos;
   tmh_pkg::tmh_hit_type              cd_hit;

   assign cd_z = signed'({3'b000, ph_val[tmh_pkg::PH_W-1:1]}) - tmh_pkg::QUARTER_TURN;

   always_comb begin
      cd_in_hit          = ph_hit;
      cd_in_hit.zero_div = ph_hit.zero_div | (field_ff && (ph_val == '0));
   end

   tmh_cordic #(
      .STAGES (CORDIC_STAGES),
      .SW     (HIT_W)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_vld  (ph_vld),
      .in_z    (cd_z),
      .in_sb   (cd_in_hit),
      .out_vld (cd_vld),
      .out_sin (cd_sin),
      .out_cos (cd_cos),
      .out_sb  (cd_hit)
   );

   // ---------------------------------------------------------------------
   // r1: rotation products and the field divisor S*P
   // ---------------------------------------------------------------------
   logic                               r1_vld_ff;
   tmh_pkg::tmh_hit_type               r1_hit_ff;
   tmh_pkg::tmh_hit_type               r1_hit_in;
   logic signed [tmh_pkg::PROD_W-1:0]  r1_xc_ff, r1_ys_ff, r1_yc_ff, r1_xs_ff;
   logic [DIVR_W-1:0]                  r1_sp_ff;

   always_comb begin
      r1_hit_in          = cd_hit;
      r1_hit_in.zero_div = cd_hit.zero_div |
                           (field_ff && (cd_sin[tmh_pkg::CORD_W-1] || cd_sin == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_vld_ff <= 1'b0;
      end else if (advance) begin
         r1_vld_ff <= cd_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_hit_ff <= r1_hit_in;
         r1_xc_ff <= cd_hit.x_pos * cd_cos;
         r1_ys_ff <= cd_hit.y_pos * cd_sin;
         r1_yc_ff <= cd_hit.y_pos * cd_cos;
         r1_xs_ff <= cd_hit.x_pos * cd_sin;
         r1_sp_ff <= {32'b0, cd_sin[tmh_pkg::CORD_W-2:0]} * {27'b0, period_ff};
      end
   end

   // ---------------------------------------------------------------------
   // r2: rotated position, magnitudes, signs and the operands per mode
   // ---------------------------------------------------------------------
   logic signed [A_W-1:0]      r2_nx, r2_ny, r2_px, r2_py;
   logic [1:0][A_W-1:0]        r2_mag;
   tmh_pkg::tmh_mul_side_type  r2_side;
   logic                       r2_vld_ff;
   logic [1:0][A_W-1:0]        r2_mag_ff;
   tmh_pkg::tmh_mul_side_type  r2_side_ff;

   always_comb begin
      if (cw_ff) begin
         r2_nx = A_W'(r1_xc_ff) - A_W'(r1_ys_ff);
         r2_ny = A_W'(r1_yc_ff) + A_W'(r1_xs_ff);
      end else begin
         r2_nx = A_W'(r1_xc_ff) + A_W'(r1_ys_ff);
         r2_ny = A_W'(r1_yc_ff) - A_W'(r1_xs_ff);
      end
      // straight flight uses the raw hit position
      r2_px = field_ff ? r2_nx : A_W'(r1_hit_ff.x_pos);
      r2_py = field_ff ? r2_ny : A_W'(r1_hit_ff.y_pos);
      r2_mag[0] = r2_px[A_W-1] ? -r2_px : r2_px;
      r2_mag[1] = r2_py[A_W-1] ? -r2_py : r2_py;

      r2_side.neg      = {r2_py[A_W-1], r2_px[A_W-1]};
      r2_side.zero_div = r1_hit_ff.zero_div;
      if (field_ff) begin
         r2_side.div       = r1_sp_ff;
         r2_side.k         = r1_hit_ff.ion ? 32'(r1_hit_ff.particle_charge)
                                           : r1_hit_ff.particle_mass;
         r2_side.pf        = tmh_pkg::PI20;
         r2_side.shift_sel = r1_hit_ff.ion ? tmh_pkg::SHIFT_ION : tmh_pkg::SHIFT_ELEC;
      end else begin
         r2_side.div       = DIVR_W'(r1_hit_ff.flight_time);
         r2_side.k         = r1_hit_ff.particle_mass;
         r2_side.pf        = 32'd1;
         r2_side.shift_sel = tmh_pkg::SHIFT_FREE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_vld_ff <= 1'b0;
      end else if (advance) begin
         r2_vld_ff <= r1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r2_mag_ff  <= r2_mag;
         r2_side_ff <= r2_side;
      end
   end

   // ---------------------------------------------------------------------
   // Numerator: |a| * V * k * pf, three wide-by-32 multiplies
   // ---------------------------------------------------------------------
   logic                       m1_vld, m2_vld, m3_vld;
   logic [1:0][A_W+31:0]       m1_p;
   logic [1:0][A_W+63:0]       m2_p;
   logic [1:0][A_W+95:0]       m3_p;
   tmh_pkg::tmh_mul_side_type  m1_side, m2_side, m3_side;

   tmh_wmul #(
      .AW (A_W),
      .SW (MUL_SW)
   ) u_mul_v (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_vld  (r2_vld_ff),
      .in_a    (r2_mag_ff),
      .in_b    (vscale_ff),
      .in_sb   (r2_side_ff),
      .out_vld (m1_vld),
      .out_p   (m1_p),
      .out_sb  (m1_side)
   );

   tmh_wmul #(
      .AW (A_W + 32),
      .SW (MUL_SW)
   ) u_mul_k (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_vld  (m1_vld),
      .in_a    (m1_p),
      .in_b    (m1_side.k),
      .in_sb   (m1_side),
      .out_vld (m2_vld),
      .out_p   (m2_p),
      .out_sb  (m2_side)
   );

   tmh_wmul #(
      .AW (A_W + 64),
      .SW (MUL_SW)
   ) u_mul_pi (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_vld  (m2_vld),
      .in_a    (m2_p),
      .in_b    (m2_side.pf),
      .in_sb   (m2_side),
      .out_vld (m3_vld),
      .out_p   (m3_p),
      .out_sb  (m3_side)
   );

   // ---------------------------------------------------------------------
   // Scale and overflow check: quotient >= 2^32 exactly when the bits above
   // the low word already reach the divisor.
   // ---------------------------------------------------------------------
   logic [1:0][P3_W-1:0]       sc_n;
   logic [1:0][HI_W-1:0]       sc_hi;
   logic [1:0]                 sc_ovf;
   logic                       sc_vld_ff;
   logic [1:0][DIVR_W-1:0]     sc_rem_ff;
   logic [1:0][31:0]           sc_low_ff;
   logic [DIVR_W-1:0]          sc_div_ff;
   tmh_pkg::tmh_div_side_type  sc_side_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         unique case (m3_side.shift_sel)
            tmh_pkg::SHIFT_FREE: sc_n[l] = m3_p[l] >> tmh_pkg::SH_FREE;
            tmh_pkg::SHIFT_ION:  sc_n[l] = m3_p[l] >> tmh_pkg::SH_ION;
            tmh_pkg::SHIFT_ELEC: sc_n[l] = m3_p[l] >> tmh_pkg::SH_ELEC;
            default:             sc_n[l] = m3_p[l] >> tmh_pkg::SH_ELEC;
         endcase
         sc_hi[l]  = sc_n[l][P3_W-1:32];
         sc_ovf[l] = sc_hi[l] >= HI_W'(m3_side.div);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff <= 1'b0;
      end else if (advance) begin
         sc_vld_ff <= m3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < 2; l++) begin
            sc_rem_ff[l] <= sc_ovf[l] ? '0 : sc_hi[l][DIVR_W-1:0];
            sc_low_ff[l] <= sc_n[l][31:0];
         end
         sc_div_ff           <= m3_side.div;
         sc_side_ff.neg      <= m3_side.neg;
         sc_side_ff.ovf      <= sc_ovf;
         sc_side_ff.zero_div <= m3_side.zero_div;
      end
   end

   // ---------------------------------------------------------------------
   // Final divide, 32 quotient bits
   // ---------------------------------------------------------------------
   logic                       qd_vld;
   logic [1:0][31:0]           qd_quo;
   tmh_pkg::tmh_div_side_type  qd_side;

   tmh_qdiv #(
      .SW (DIV_SW)
   ) u_qdiv (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_vld  (sc_vld_ff),
      .in_rem  (sc_rem_ff),
      .in_low  (sc_low_ff),
      .in_div  (sc_div_ff),
      .in_sb   (sc_side_ff),
      .out_vld (qd_vld),
      .out_quo (qd_quo),
      .out_sb  (qd_side)
   );

   // ---------------------------------------------------------------------
   // Saturate, sign and status into the output register
   // ---------------------------------------------------------------------
   logic [1:0][31:0]         out_lim, out_val, out_mom;
   logic [1:0]               out_sat;
   tmh_pkg::tmh_status_type  out_status;
   logic [63:0]              rsp_data_ff;
   logic [1:0]               rsp_user_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         out_lim[l] = qd_side.neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         out_sat[l] = qd_side.ovf[l] || (qd_quo[l] > out_lim[l]);
         out_val[l] = out_sat[l] ? out_lim[l] : qd_quo[l];
         out_mom[l] = qd_side.neg[l] ? -out_val[l] : out_val[l];
      end
      if (qd_side.zero_div) begin
         out_mom    = '0;
         out_status = tmh_pkg::STATUS_ZERO_DIV;
      end else if (|out_sat) begin
         out_status = tmh_pkg::STATUS_SAT;
      end else begin
         out_status = tmh_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= qd_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {out_mom[1], out_mom[0]};
         rsp_user_ff <= out_status;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_zero_div_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tmh_pkg::STATUS_ZERO_DIV) |-> rsp_tdata == '0)
      else $error("zero divisor word carries nonzero momentum");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tmh_pkg::STATUS_SAT) |->
         (rsp_tdata[31:0] == 32'h7FFF_FFFF) || (rsp_tdata[31:0] == 32'h8000_0000) ||
         (rsp_tdata[63:32] == 32'h7FFF_FFFF) || (rsp_tdata[63:32] == 32'h8000_0000))
      else $error("saturated word has no clamped momentum");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while the pipeline is stalled");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word valid right after reset");

endmodule
